/* rtl/core/mprb_pkg.sv */
// shared types, codes and defaults of the multi pipe ring buffer
package mprb_pkg;

    localparam int PIPE_COUNT_DEF     = 16;
    localparam int PIPE_BYTES_DEF     = 4096;
    localparam int MAX_READ_BURST_DEF = 64;

    localparam logic [2:0] MODE_CREATE   = 3'd0;
    localparam logic [2:0] MODE_WRITE    = 3'd1;
    localparam logic [2:0] MODE_READ     = 3'd2;
    localparam logic [2:0] MODE_CLOSE_RD = 3'd3;
    localparam logic [2:0] MODE_CLOSE_WR = 3'd4;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_EMPTY      = 3'd1;
    localparam logic [2:0] STATUS_FULL       = 3'd2;
    localparam logic [2:0] STATUS_NOT_IN_USE = 3'd3;
    localparam logic [2:0] STATUS_NO_FREE    = 3'd4;
    localparam logic [2:0] STATUS_ZERO_LEN   = 3'd5;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] pipe;
        logic [7:0] write_data;
        logic [6:0] request_length;
    } in_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data;
        logic [3:0] pipe_index;
        logic       last;
        logic       end_of_file;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_RD_ADDR,
        S_RD_OUT,
        S_RESP
    } ctrl_state_t;

endpackage

/* rtl/core/mprb_byte_ram.sv */
// byte storage of all pipes, one access per cycle, registered read
module mprb_byte_ram #(
    parameter int ADDR_W = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

/* rtl/core/mprb_state_ram.sv */
// per pipe pointer and count table, one write and one registered read per cycle
module mprb_state_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int WORD_W = 37
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/mprb_ctrl.sv */
// sequencer with shared pointer and count unit, pipe flags and table access
module mprb_ctrl #(
    parameter int PIPE_COUNT     = mprb_pkg::PIPE_COUNT_DEF,
    parameter int PIPE_BYTES     = mprb_pkg::PIPE_BYTES_DEF,
    parameter int MAX_READ_BURST = mprb_pkg::MAX_READ_BURST_DEF,
    parameter int PIPE_W         = 4,
    parameter int PTR_W          = 12,
    parameter int CNT_W          = 13,
    parameter int ST_W           = 37
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  mprb_pkg::in_word_t       req,
    output logic                     res_valid,
    input  logic                     res_ready,
    output mprb_pkg::out_word_t      res,
    output logic                     st_wr_en,
    output logic [PIPE_W-1:0]        st_waddr,
    output logic [ST_W-1:0]          st_wdata,
    output logic [PIPE_W-1:0]        st_raddr,
    input  logic [ST_W-1:0]          st_rdata,
    output logic                     byte_wr_en,
    output logic                     byte_rd_en,
    output logic [PIPE_W+PTR_W-1:0]  byte_addr,
    output logic [7:0]               byte_wdata,
    input  logic [7:0]               byte_rdata
);

    localparam int RB_W  = (MAX_READ_BURST > 1) ? $clog2(MAX_READ_BURST + 1) : 1;
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    mprb_pkg::ctrl_state_t state_reg, state_next;
    logic [2:0]            mode_reg, mode_next;
    logic [PIPE_W-1:0]     pipe_reg, pipe_next;
    logic                  pvalid_reg, pvalid_next;
    logic [7:0]            wdata_reg, wdata_next;
    logic [6:0]            len_reg, len_next;
    logic [PIPE_W-1:0]     scan_reg, scan_next;
    logic [PTR_W-1:0]      wptr_reg, wptr_next;
    logic [PTR_W-1:0]      rptr_reg, rptr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [RB_W-1:0]       remain_reg, remain_next;
    mprb_pkg::out_word_t   res_reg, res_next;
    logic [PIPE_COUNT-1:0] busy_reg, busy_next;
    logic [PIPE_COUNT-1:0] ropen_reg, ropen_next;
    logic [PIPE_COUNT-1:0] wopen_reg, wopen_next;

    logic [8:0]        req_ext;
    logic [PIPE_W-1:0] req_idx;
    logic              req_in_range;
    logic [8:0]        scan_ext;
    logic [PTR_W-1:0]  st_wptr, st_rptr;
    logic [CNT_W-1:0]  st_cnt;
    logic [PTR_W-1:0]  ptr_sel, ptr_inc;
    logic [CNT_W-1:0]  cnt_sel, cnt_up, cnt_dn;
    logic [6:0]        len_sat;
    logic [RB_W-1:0]   burst_n;

    assign req_ext      = 9'(req.pipe);
    assign req_idx      = req_ext[PIPE_W-1:0];
    assign req_in_range = (req_ext < 9'(PIPE_COUNT));
    assign scan_ext     = 9'(scan_reg);

    assign st_wptr = st_rdata[ST_W-1 -: PTR_W];
    assign st_rptr = st_rdata[CNT_W+PTR_W-1 -: PTR_W];
    assign st_cnt  = st_rdata[CNT_W-1:0];

    // shared pointer and count unit
    assign ptr_sel = (state_reg == mprb_pkg::S_EXEC) ? st_wptr : rptr_reg;
    assign ptr_inc = (ptr_sel == PTR_W'(PIPE_BYTES - 1)) ? '0 : ptr_sel + 1'b1;
    assign cnt_sel = (state_reg == mprb_pkg::S_EXEC) ? st_cnt : cnt_reg;
    assign cnt_up  = cnt_sel + 1'b1;
    assign cnt_dn  = cnt_sel - 1'b1;

    assign len_sat = (len_reg > 7'(MAX_READ_BURST)) ? 7'(MAX_READ_BURST) : len_reg;
    assign burst_n = (CMP_W'(len_sat) < CMP_W'(st_cnt)) ? RB_W'(len_sat) : RB_W'(st_cnt);

    assign st_raddr   = (state_reg == mprb_pkg::S_IDLE) ? req_idx : pipe_reg;
    assign byte_addr  = {pipe_reg, ptr_sel};
    assign byte_wdata = wdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mprb_pkg::S_IDLE;
            busy_reg  <= '0;
            ropen_reg <= '0;
            wopen_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            ropen_reg <= ropen_next;
            wopen_reg <= wopen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        pipe_reg   <= pipe_next;
        pvalid_reg <= pvalid_next;
        wdata_reg  <= wdata_next;
        len_reg    <= len_next;
        scan_reg   <= scan_next;
        wptr_reg   <= wptr_next;
        rptr_reg   <= rptr_next;
        cnt_reg    <= cnt_next;
        remain_reg <= remain_next;
        res_reg    <= res_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        pipe_next   = pipe_reg;
        pvalid_next = pvalid_reg;
        wdata_next  = wdata_reg;
        len_next    = len_reg;
        scan_next   = scan_reg;
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        cnt_next    = cnt_reg;
        remain_next = remain_reg;
        res_next    = res_reg;
        busy_next   = busy_reg;
        ropen_next  = ropen_reg;
        wopen_next  = wopen_reg;
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        res         = res_reg;
        st_wr_en    = 1'b0;
        st_waddr    = pipe_reg;
        st_wdata    = {wptr_reg, rptr_reg, cnt_reg};
        byte_wr_en  = 1'b0;
        byte_rd_en  = 1'b0;

        unique case (state_reg)
            mprb_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    mode_next   = req.mode;
                    pipe_next   = req_idx;
                    pvalid_next = req_in_range && busy_reg[req_idx];
                    wdata_next  = req.write_data;
                    len_next    = req.request_length;
                    scan_next   = '0;
                    if (req.mode == mprb_pkg::MODE_CREATE)
                    begin
                        state_next = mprb_pkg::S_SCAN;
                    end
                    else if (req.mode > mprb_pkg::MODE_CLOSE_WR)
                    begin
                        state_next = mprb_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = mprb_pkg::S_EXEC;
                    end
                end
            end

            mprb_pkg::S_SCAN:
            begin
                res_next = '0;
                res_next.last = 1'b1;
                if (!busy_reg[scan_reg])
                begin
                    st_wr_en              = 1'b1;
                    st_waddr              = scan_reg;
                    st_wdata              = '0;
                    busy_next[scan_reg]   = 1'b1;
                    ropen_next[scan_reg]  = 1'b1;
                    wopen_next[scan_reg]  = 1'b1;
                    res_next.status       = mprb_pkg::STATUS_OK;
                    res_next.pipe_index   = scan_ext[3:0];
                    state_next            = mprb_pkg::S_RESP;
                end
                else if (scan_ext == 9'(PIPE_COUNT - 1))
                begin
                    res_next.status = mprb_pkg::STATUS_NO_FREE;
                    state_next      = mprb_pkg::S_RESP;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            mprb_pkg::S_EXEC:
            begin
                res_next        = '0;
                res_next.last   = 1'b1;
                res_next.status = mprb_pkg::STATUS_OK;
                state_next      = mprb_pkg::S_RESP;
                if (!pvalid_reg)
                begin
                    res_next.status = mprb_pkg::STATUS_NOT_IN_USE;
                end
                else
                begin
                    unique case (mode_reg)
                        mprb_pkg::MODE_WRITE:
                        begin
                            if (st_cnt >= CNT_W'(PIPE_BYTES))
                            begin
                                res_next.status = mprb_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                byte_wr_en = 1'b1;
                                st_wr_en   = 1'b1;
                                st_wdata   = {ptr_inc, st_rptr, cnt_up};
                            end
                        end
                        mprb_pkg::MODE_READ:
                        begin
                            if (len_reg == 7'd0)
                            begin
                                res_next.status = mprb_pkg::STATUS_ZERO_LEN;
                            end
                            else if (st_cnt == '0)
                            begin
                                res_next.status      = mprb_pkg::STATUS_EMPTY;
                                res_next.end_of_file = !wopen_reg[pipe_reg];
                            end
                            else
                            begin
                                wptr_next   = st_wptr;
                                rptr_next   = st_rptr;
                                cnt_next    = st_cnt;
                                remain_next = burst_n;
                                state_next  = mprb_pkg::S_RD_ADDR;
                            end
                        end
                        mprb_pkg::MODE_CLOSE_RD:
                        begin
                            ropen_next[pipe_reg] = 1'b0;
                            if (!wopen_reg[pipe_reg])
                            begin
                                busy_next[pipe_reg] = 1'b0;
                            end
                        end
                        mprb_pkg::MODE_CLOSE_WR:
                        begin
                            wopen_next[pipe_reg] = 1'b0;
                            if (!ropen_reg[pipe_reg])
                            begin
                                busy_next[pipe_reg] = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = mprb_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            mprb_pkg::S_RD_ADDR:
            begin
                byte_rd_en = 1'b1;
                state_next = mprb_pkg::S_RD_OUT;
            end

            mprb_pkg::S_RD_OUT:
            begin
                res_valid      = 1'b1;
                res            = '0;
                res.status     = mprb_pkg::STATUS_OK;
                res.data       = byte_rdata;
                res.last       = (remain_reg == RB_W'(1));
                if (res_ready)
                begin
                    rptr_next   = ptr_inc;
                    cnt_next    = cnt_dn;
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == RB_W'(1))
                    begin
                        st_wr_en   = 1'b1;
                        st_wdata   = {wptr_reg, ptr_inc, cnt_dn};
                        state_next = mprb_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = mprb_pkg::S_RD_ADDR;
                    end
                end
            end

            mprb_pkg::S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = mprb_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mprb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/multi_pipe_ring_buffer_top.sv */
// multi pipe ring buffer top level: sequencer, memories and output register
// usage:
//   req channel (req_valid/req_ready, req word): one command per word,
//   create, write one byte, read a burst, close read end, close write end.
//   rsp channel (rsp_valid/rsp_ready, rsp word): one word per result; a read
//   gives one word per delivered byte, the final word of a command has last.
//   commands are taken one at a time; req_ready is high only while idle.
//   steps per command, from acceptance until ready again:
//     write, close, errors: table lookup, then result; unknown mode: no result
//     create: scan up from pipe 0 to the lowest free pipe, all pipes if none
//     read of n bytes: one byte ram read and one output slot per byte
//   every result word goes out through the output register; a read takes
//   its bytes from the single port byte ram after the lookup in the per
//   pipe pointer table.
//   reset: all pipes free, no clearing pass, ready right after reset.
//   stall: a result waits in the output register; while it is held the
//   sequencer stops at its next result and no word is lost or repeated.
module multi_pipe_ring_buffer_top #(
    parameter int PIPE_COUNT     = mprb_pkg::PIPE_COUNT_DEF,
    parameter int PIPE_BYTES     = mprb_pkg::PIPE_BYTES_DEF,
    parameter int MAX_READ_BURST = mprb_pkg::MAX_READ_BURST_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  mprb_pkg::in_word_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output mprb_pkg::out_word_t rsp
);

    localparam int PIPE_W = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
    localparam int PTR_W  = $clog2(PIPE_BYTES);
    localparam int CNT_W  = $clog2(PIPE_BYTES + 1);
    localparam int ST_W   = 2 * PTR_W + CNT_W;

    logic                    res_valid;
    logic                    res_ready;
    mprb_pkg::out_word_t     res;
    logic                    st_wr_en;
    logic [PIPE_W-1:0]       st_waddr;
    logic [ST_W-1:0]         st_wdata;
    logic [PIPE_W-1:0]       st_raddr;
    logic [ST_W-1:0]         st_rdata;
    logic                    byte_wr_en;
    logic                    byte_rd_en;
    logic [PIPE_W+PTR_W-1:0] byte_addr;
    logic [7:0]              byte_wdata;
    logic [7:0]              byte_rdata;

    logic                    out_valid_reg, out_valid_next;
    mprb_pkg::out_word_t     out_word_reg, out_word_next;

    mprb_byte_ram #(
        .ADDR_W (PIPE_W + PTR_W)
    ) u_byte_ram (
        .clk   (clk),
        .wr_en (byte_wr_en),
        .rd_en (byte_rd_en),
        .addr  (byte_addr),
        .wdata (byte_wdata),
        .rdata (byte_rdata)
    );

    mprb_state_ram #(
        .DEPTH  (PIPE_COUNT),
        .ADDR_W (PIPE_W),
        .WORD_W (ST_W)
    ) u_state_ram (
        .clk   (clk),
        .wr_en (st_wr_en),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    mprb_ctrl #(
        .PIPE_COUNT     (PIPE_COUNT),
        .PIPE_BYTES     (PIPE_BYTES),
        .MAX_READ_BURST (MAX_READ_BURST),
        .PIPE_W         (PIPE_W),
        .PTR_W          (PTR_W),
        .CNT_W          (CNT_W),
        .ST_W           (ST_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .st_wr_en   (st_wr_en),
        .st_waddr   (st_waddr),
        .st_wdata   (st_wdata),
        .st_raddr   (st_raddr),
        .st_rdata   (st_rdata),
        .byte_wr_en (byte_wr_en),
        .byte_rd_en (byte_rd_en),
        .byte_addr  (byte_addr),
        .byte_wdata (byte_wdata),
        .byte_rdata (byte_rdata)
    );

    // output register
    assign res_ready = !out_valid_reg || rsp_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_word_next  = res;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_word_reg;

    // one command at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.mode <= mprb_pkg::MODE_CLOSE_WR) |=> !req_ready)
        else $error("command accepted while another is in progress");

    // non ok status words always close a command
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != mprb_pkg::STATUS_OK) |-> rsp.last)
        else $error("non ok status word without last");

    // end of file only on an empty read
    a_eof_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.end_of_file) |-> (rsp.status == mprb_pkg::STATUS_EMPTY))
        else $error("end of file on a non empty result");

    // no result word while idle and ready for a new command
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !res_valid)
        else $error("result produced while idle");

endmodule

/* tb/tb.sv */
// testbench for the multi pipe ring buffer: directed and random pipe commands checked against a pipe pool model
module tb;
    import mprb_pkg::*;

    localparam int PIPES = PIPE_COUNT_DEF;
    localparam int DEPTH = PIPE_BYTES_DEF;
    localparam int BURST = MAX_READ_BURST_DEF;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    in_word_t    req;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    out_word_t   rsp;

    bit          steady = 1'b0;
    int          errors = 0;

    // pool model state
    logic [7:0]       ring_mem [PIPES * DEPTH];
    logic [PTR_W-1:0] wr_ptr   [PIPES];
    logic [PTR_W-1:0] rd_ptr   [PIPES];
    logic [LVL_W-1:0] level    [PIPES];
    bit               busy     [PIPES];
    bit               rd_open  [PIPES];
    bit               wr_open  [PIPES];

    out_word_t        pipe_results_due [$];
    out_word_t        want;

    multi_pipe_ring_buffer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #24_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge clk)
    begin
        rsp_ready <= steady || ($urandom_range(0, 99) >= 10);
    end

    function automatic in_word_t cmd(input logic [2:0] m, input int p, input int d,
                                     input int len);
        in_word_t w;
        w.mode           = m;
        w.pipe           = 4'(p);
        w.write_data     = 8'(d);
        w.request_length = 7'(len);
        return w;
    endfunction

    // expected results of one accepted command, pool state updated
    function automatic void pipe_pool_step(input in_word_t w);
        int        p;
        int        n;
        int        len;
        out_word_t r;
        p = w.pipe;
        r = '0;
        r.last = 1'b1;
        if (w.mode == MODE_CREATE)
        begin
            r.status = STATUS_NO_FREE;
            for (int i = 0; i < PIPES; i++)
            begin
                if (!busy[i])
                begin
                    wr_ptr[i]    = '0;
                    rd_ptr[i]    = '0;
                    level[i]     = '0;
                    rd_open[i]   = 1'b1;
                    wr_open[i]   = 1'b1;
                    busy[i]      = 1'b1;
                    r.status     = STATUS_OK;
                    r.pipe_index = 4'(i);
                    break;
                end
            end
            pipe_results_due.push_back(r);
            return;
        end
        if (w.mode > MODE_CLOSE_WR)
            return;
        if (p >= PIPES || !busy[p])
        begin
            r.status = STATUS_NOT_IN_USE;
            pipe_results_due.push_back(r);
            return;
        end
        case (w.mode)
            MODE_WRITE:
            begin
                if (level[p] >= DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    ring_mem[p * DEPTH + wr_ptr[p]] = w.write_data;
                    wr_ptr[p] = PTR_W'((wr_ptr[p] + 1) % DEPTH);
                    level[p]  = level[p] + 1'b1;
                    r.status  = STATUS_OK;
                end
                pipe_results_due.push_back(r);
            end
            MODE_READ:
            begin
                len = w.request_length;
                if (len == 0)
                begin
                    r.status = STATUS_ZERO_LEN;
                    pipe_results_due.push_back(r);
                end
                else if (level[p] == 0)
                begin
                    r.status      = STATUS_EMPTY;
                    r.end_of_file = !wr_open[p];
                    pipe_results_due.push_back(r);
                end
                else
                begin
                    if (len > BURST)
                        len = BURST;
                    n = (len < level[p]) ? len : level[p];
                    for (int k = 0; k < n; k++)
                    begin
                        r.status = STATUS_OK;
                        r.data   = ring_mem[p * DEPTH + rd_ptr[p]];
                        r.last   = (k + 1 == n);
                        rd_ptr[p] = PTR_W'((rd_ptr[p] + 1) % DEPTH);
                        pipe_results_due.push_back(r);
                    end
                    level[p] = level[p] - LVL_W'(n);
                end
            end
            default:
            begin
                if (w.mode == MODE_CLOSE_RD)
                    rd_open[p] = 1'b0;
                else
                    wr_open[p] = 1'b0;
                if (!rd_open[p] && !wr_open[p])
                    busy[p] = 1'b0;
                r.status = STATUS_OK;
                pipe_results_due.push_back(r);
            end
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input in_word_t w);
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pipe_pool_step(w);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] exp);
        if (got !== exp)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pipe_results_due.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %p", $time, rsp);
                errors++;
            end
            else
            begin
                want = pipe_results_due.pop_front();
                check_field("status", 8'(rsp.status), 8'(want.status));
                check_field("data", rsp.data, want.data);
                check_field("pipe_index", 8'(rsp.pipe_index), 8'(want.pipe_index));
                check_field("last", 8'(rsp.last), 8'(want.last));
                check_field("end_of_file", 8'(rsp.end_of_file), 8'(want.end_of_file));
            end
        end
    end

    task automatic open_pipe(output int p);
        p = -1;
        for (int i = PIPES - 1; i >= 0; i--)
            if (!busy[i])
                p = i;
        send_word(cmd(MODE_CREATE, 0, 0, 0));
    endtask

    task automatic close_pipe(input int p);
        send_word(cmd(MODE_CLOSE_RD, p, 0, 0));
        send_word(cmd(MODE_CLOSE_WR, p, 0, 0));
    endtask

    task automatic test_unused_pipes;
        send_word(cmd(MODE_WRITE, 0, 8'hA5, 0));
        send_word(cmd(MODE_READ, PIPES - 1, 0, 1));
        send_word(cmd(MODE_READ, 7, 0, 0));
        send_word(cmd(MODE_CLOSE_RD, 0, 0, 0));
        send_word(cmd(MODE_CLOSE_WR, PIPES - 1, 0, 0));
        for (int m = MODE_CLOSE_WR + 1; m < 8; m++)
            send_word(cmd(3'(m), 15, 8'hFF, 127));
    endtask

    task automatic test_pool_exhaust;
        for (int i = 0; i <= PIPES; i++)
            send_word(cmd(MODE_CREATE, PIPES - 1, 8'hFF, 127));
        send_word(cmd(MODE_CLOSE_RD, 5, 0, 0));
        send_word(cmd(MODE_CLOSE_RD, 5, 0, 0));
        send_word(cmd(MODE_CREATE, 0, 0, 0));
        send_word(cmd(MODE_CLOSE_WR, 5, 0, 0));
        send_word(cmd(MODE_CLOSE_RD, 5, 0, 0));
        send_word(cmd(MODE_CREATE, 0, 0, 0));
        for (int i = 0; i < PIPES; i++)
            close_pipe(i);
    endtask

    task automatic test_byte_transfer;
        int p;
        open_pipe(p);
        send_word(cmd(MODE_WRITE, p, 8'h00, 0));
        send_word(cmd(MODE_WRITE, p, 8'hFF, 0));
        send_word(cmd(MODE_WRITE, p, 8'h5A, 0));
        send_word(cmd(MODE_READ, p, 0, 0));
        send_word(cmd(MODE_READ, p, 0, 1));
        send_word(cmd(MODE_READ, p, 0, BURST));
        send_word(cmd(MODE_READ, p, 0, 3));
        send_word(cmd(MODE_CLOSE_WR, p, 0, 0));
        send_word(cmd(MODE_READ, p, 0, 1));
        send_word(cmd(MODE_WRITE, p, 8'h81, 0));
        send_word(cmd(MODE_READ, p, 0, 127));
        send_word(cmd(MODE_CLOSE_WR, p, 0, 0));
        send_word(cmd(MODE_CLOSE_RD, p, 0, 0));
        send_word(cmd(MODE_READ, p, 0, 1));
    endtask

    task automatic test_burst_limit;
        int p;
        open_pipe(p);
        repeat (BURST + 6)
            send_word(cmd(MODE_WRITE, p, $urandom_range(0, 255), 0));
        send_word(cmd(MODE_READ, p, 0, 127));
        send_word(cmd(MODE_READ, p, 0, BURST + 1));
        close_pipe(p);
    endtask

    task automatic test_fill_drain;
        int p;
        open_pipe(p);
        // move the pointers off zero first
        repeat (10)
            send_word(cmd(MODE_WRITE, p, $urandom_range(0, 255), 0));
        send_word(cmd(MODE_READ, p, 0, 10));
        repeat (30)
            send_word(cmd(MODE_WRITE, p, $urandom_range(0, 255), 0));
        while (level[p] != 0)
            send_word(cmd(MODE_READ, p, 0, 7));
        send_word(cmd(MODE_READ, p, 0, BURST));
        close_pipe(p);
    endtask

    task automatic test_random_traffic(input int total);
        int       done_cnt;
        int       sel;
        int       p;
        int       open_list [$];
        in_word_t w;
        done_cnt = 0;
        while (done_cnt < total)
        begin
            steady = (done_cnt > total / 3) && (done_cnt < total / 2);
            open_list.delete();
            for (int i = 0; i < PIPES; i++)
                if (busy[i])
                    open_list.push_back(i);
            p = (open_list.size() == 0) ? -1
                : open_list[$urandom_range(0, open_list.size() - 1)];
            sel = $urandom_range(0, 99);
            w = cmd(MODE_CREATE, $urandom_range(0, 15), $urandom_range(0, 255),
                    $urandom_range(0, 127));
            if (sel >= 84 && sel < 96)
                w.mode = 3'($urandom_range(MODE_CREATE, MODE_CLOSE_WR));
            else if (sel >= 96)
                w.mode = 3'($urandom_range(MODE_CLOSE_WR + 1, 7));
            else if (p >= 0 && sel >= 6)
            begin
                if (sel < 50)
                    w = cmd(MODE_WRITE, p, $urandom_range(0, 255), 0);
                else if (sel < 72)
                    w = cmd(MODE_READ, p, 0, ($urandom_range(0, 9) == 0)
                            ? $urandom_range(0, 127) : $urandom_range(1, 8));
                else if (sel < 78)
                    w = cmd(MODE_CLOSE_RD, p, 0, 0);
                else
                    w = cmd(MODE_CLOSE_WR, p, 0, 0);
            end
            send_word(w);
            if (w.mode <= MODE_CLOSE_WR)
                done_cnt++;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_unused_pipes;
        test_pool_exhaust;
        test_byte_transfer;
        test_burst_limit;
        test_fill_drain;
        test_random_traffic(240);
        req_valid <= 1'b0;
        while (pipe_results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
